/* rtl/core/edtd_pkg.sv */
`timescale 1ns / 1ps

package edtd_pkg;

	// descriptor geometry
	localparam int DESC_LEN   = 18;
	localparam int STORE_LEN  = DESC_LEN - 1;
	localparam int LAST_POS   = DESC_LEN - 1;
	localparam int POS_W      = $clog2(DESC_LEN);
	localparam int STORE_IDX_W = $clog2(STORE_LEN);

	// queue depths
	localparam int JOB_DEPTH_DEF = 2;
	localparam int OUT_DEPTH_DEF = 2;

	// aspect pairs that carry no physical size
	localparam logic [11:0] ASPECT_WIDE_H = 12'd16;
	localparam logic [11:0] ASPECT_WIDE_V = 12'd9;
	localparam logic [11:0] ASPECT_STD_H  = 12'd4;
	localparam logic [11:0] ASPECT_STD_V  = 12'd3;

	// axis codes
	localparam logic AXIS_H = 1'b0;
	localparam logic AXIS_V = 1'b1;

	typedef enum logic [2:0] {
		STEREO_NONE      = 3'd0,
		STEREO_SEQ_RIGHT = 3'd1,
		STEREO_SEQ_LEFT  = 3'd2,
		STEREO_2W_RIGHT  = 3'd3,
		STEREO_2W_LEFT   = 3'd4,
		STEREO_4W        = 3'd5,
		STEREO_SIDE      = 3'd6
	} stereo_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
	} in_t;

	typedef struct packed {
		logic        axis;
		logic [11:0] active;
		logic [11:0] blank;
		logic [9:0]  front_porch;
		logic [9:0]  sync_width;
		logic [11:0] image_mm;
		logic [7:0]  border;
		logic [15:0] pixel_clock_10khz;
		logic        interlaced;
		logic [2:0]  stereo_mode;
		logic        is_timing;
		logic        last;
	} out_t;

	// values of one axis
	typedef struct packed {
		logic [11:0] active;
		logic [11:0] blank;
		logic [9:0]  front_porch;
		logic [9:0]  sync_width;
		logic [11:0] image_mm;
		logic [7:0]  border;
	} axis_vals_t;

	// one classified descriptor handed from front to back
	typedef struct packed {
		logic        is_timing;
		logic [15:0] pixel_clock_10khz;
		logic        interlaced;
		logic [2:0]  stereo_mode;
		axis_vals_t  h;
		axis_vals_t  v;
	} job_t;

	// stereo field of the flags byte, renumbered densely
	function automatic stereo_t stereo_code(input logic [7:0] flags);
		stereo_t r;
		unique case ({flags[6:5], flags[0]})
			3'b010:  r = STEREO_SEQ_RIGHT;
			3'b100:  r = STEREO_SEQ_LEFT;
			3'b011:  r = STEREO_2W_RIGHT;
			3'b101:  r = STEREO_2W_LEFT;
			3'b110:  r = STEREO_4W;
			3'b111:  r = STEREO_SIDE;
			default: r = STEREO_NONE;
		endcase
		return r;
	endfunction

endpackage

/* rtl/core/edid_detailed_timing_decoder.sv */
`timescale 1ns / 1ps

// channel   ports                  transfer when
// input     item, push, full       push && !full
// result    result, pop, empty     pop && !empty
//
// one byte is taken per cycle while full is low; the flags byte closes a
// descriptor and files one job into the job queue, which the back end turns
// into one result (display descriptor) or two results (horizontal, vertical).
// with a job waiting, the back end writes one result per cycle into a non-full result queue.
// reset clears the byte position, the axis step and both queue counts.
// full rises only while the job queue holds JobDepth descriptors not yet drained;
// a stalled result side fills the result queue and then the job queue.

module edid_detailed_timing_decoder import edtd_pkg::*; #(
	parameter int JobDepth = JOB_DEPTH_DEF,
	parameter int OutDepth = OUT_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  in_t  item,
	output logic empty,
	input  logic pop,
	output out_t result
);

	job_t job_in, job_out;
	logic job_push, job_pop, job_full, job_empty;

	assign full = job_full;

	edtd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.item    (item),
		.job_full(job_full),
		.job_push(job_push),
		.job     (job_in)
	);

	edtd_fifo #(
		.DEPTH(JobDepth),
		.WIDTH($bits(job_t))
	) u_job_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (job_push),
		.wdata (job_in),
		.full  (job_full),
		.pop   (job_pop),
		.rdata (job_out),
		.empty (job_empty)
	);

	edtd_back #(
		.OUT_DEPTH(OutDepth)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job      (job_out),
		.job_empty(job_empty),
		.job_pop  (job_pop),
		.result   (result),
		.empty    (empty),
		.pop      (pop)
	);

endmodule

/* rtl/core/edtd_fifo.sv */
`timescale 1ns / 1ps

module edtd_fifo #(
	parameter int DEPTH = 2,
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rdata   = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_q + 1'b1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_q + 1'b1);
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= CNT_W'(cnt_q + 1'b1);
				2'b01:   cnt_q <= CNT_W'(cnt_q - 1'b1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* rtl/core/edtd_front.sv */
`timescale 1ns / 1ps

module edtd_front import edtd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  in_t  item,
	input  logic job_full,
	output logic job_push,
	output job_t job
);

	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] pos_eff;
	logic [7:0]       bytes_q [STORE_LEN];
	logic             accept;
	logic             is_last;
	logic [15:0]      pclk;
	axis_vals_t       hv, vv;
	logic             aspect_only;

	// input transfer, full follows the job queue
	assign accept  = push & ~job_full;
	assign pos_eff = item.first_byte ? '0 : pos_q;
	assign is_last = (pos_eff >= POS_W'(LAST_POS));
	assign job_push = accept & is_last;

	// byte position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			pos_q <= is_last ? '0 : POS_W'(pos_eff + 1'b1);
		end
	end

	// descriptor bytes 0..16
	always_ff @(posedge clk) begin
		if (accept && !is_last) begin
			bytes_q[pos_eff[STORE_IDX_W-1:0]] <= item.data_byte;
		end
	end

	// field unpacking from the stored bytes
	always_comb begin
		pclk = {bytes_q[1], bytes_q[0]};
		hv.active      = {bytes_q[4][7:4], bytes_q[2]};
		hv.blank       = {bytes_q[4][3:0], bytes_q[3]};
		hv.front_porch = {bytes_q[11][7:6], bytes_q[8]};
		hv.sync_width  = {bytes_q[11][5:4], bytes_q[9]};
		hv.image_mm    = {bytes_q[14][7:4], bytes_q[12]};
		hv.border      = bytes_q[15];
		vv.active      = {bytes_q[7][7:4], bytes_q[5]};
		vv.blank       = {bytes_q[7][3:0], bytes_q[6]};
		vv.front_porch = {4'd0, bytes_q[11][3:2], bytes_q[10][7:4]};
		vv.sync_width  = {4'd0, bytes_q[11][1:0], bytes_q[10][3:0]};
		vv.image_mm    = {bytes_q[14][3:0], bytes_q[13]};
		vv.border      = bytes_q[16];
		aspect_only = (hv.image_mm == ASPECT_WIDE_H && vv.image_mm == ASPECT_WIDE_V) ||
			(hv.image_mm == ASPECT_STD_H && vv.image_mm == ASPECT_STD_V);
		if (aspect_only) begin
			hv.image_mm = '0;
			vv.image_mm = '0;
		end
	end

	// classification: timing or display descriptor
	always_comb begin
		job = '0;
		if (pclk != '0) begin
			job.is_timing         = 1'b1;
			job.pixel_clock_10khz = pclk;
			job.interlaced        = item.data_byte[7];
			job.stereo_mode       = stereo_code(item.data_byte);
			job.h                 = hv;
			job.v                 = vv;
		end
	end

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_W'(LAST_POS))
		else $error("byte position beyond descriptor");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.first_byte |=> pos_q == POS_W'(1))
		else $error("first byte did not restart position");

	a_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		job_push |=> pos_q == '0)
		else $error("position not cleared after final byte");

endmodule

/* rtl/core/edtd_back.sv */
`timescale 1ns / 1ps

module edtd_back import edtd_pkg::*; #(
	parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  job_t job,
	input  logic job_empty,
	output logic job_pop,
	output out_t result,
	output logic empty,
	input  logic pop
);

	logic       axis_q;
	logic       out_full;
	logic       emit;
	out_t       res;
	axis_vals_t vals;

	assign emit    = ~job_empty & ~out_full;
	assign job_pop = emit & res.last;

	// build the result for the current axis
	always_comb begin
		vals                  = (axis_q == AXIS_V) ? job.v : job.h;
		res.axis              = axis_q;
		res.active            = vals.active;
		res.blank             = vals.blank;
		res.front_porch       = vals.front_porch;
		res.sync_width        = vals.sync_width;
		res.image_mm          = vals.image_mm;
		res.border            = vals.border;
		res.pixel_clock_10khz = job.pixel_clock_10khz;
		res.interlaced        = job.interlaced;
		res.stereo_mode       = job.stereo_mode;
		res.is_timing         = job.is_timing;
		res.last              = ~job.is_timing | (axis_q == AXIS_V);
	end

	// axis step: horizontal first, then vertical
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_q <= AXIS_H;
		end else if (emit) begin
			axis_q <= res.last ? AXIS_H : AXIS_V;
		end
	end

	// result queue
	edtd_fifo #(
		.DEPTH(OUT_DEPTH),
		.WIDTH($bits(out_t))
	) u_out_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (emit),
		.wdata (res),
		.full  (out_full),
		.pop   (pop),
		.rdata (result),
		.empty (empty)
	);

	a_axis_job: assert property (@(posedge clk) disable iff (!arst_n)
		axis_q == AXIS_V |-> !job_empty && job.is_timing)
		else $error("vertical step without a pending timing job");

	a_h_then_v: assert property (@(posedge clk) disable iff (!arst_n)
		emit && job.is_timing && axis_q == AXIS_H |=> axis_q == AXIS_V)
		else $error("horizontal result not followed by vertical step");

	a_hold_job: assert property (@(posedge clk) disable iff (!arst_n)
		axis_q == AXIS_V && !emit |=> axis_q == AXIS_V && $stable(job))
		else $error("job changed while vertical result pending");

endmodule
